### hw/rtl/wra_pkg.sv
package wra_pkg;

  localparam int DATA_W      = 32;
  localparam int WINDOW_BITS = 10;
  localparam int WIN_IN_W    = 10;
  localparam int SEEN_W      = 10;
  localparam int OP_W        = 2;

  localparam logic [WINDOW_BITS-1:0] DEFAULT_WINDOW = WINDOW_BITS'(10);

  // Widest numerator: window-sized weight times a Q15.16 value, plus one sample.
  localparam int NUM_W     = DATA_W + WINDOW_BITS + 1;
  localparam int MUL_CNT_W = $clog2(WINDOW_BITS);
  localparam int DIV_CNT_W = $clog2(NUM_W);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE  = 2'd0,
    OP_INIT    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_RESCALE = 2'd3
  } op_t;

  typedef logic [WINDOW_BITS-1:0] win_t;
  typedef logic [NUM_W-1:0]       num_t;

  // A zero window is taken as one so that no divisor is ever zero.
  function automatic win_t legal_window(input logic [WIN_IN_W-1:0] w);
    win_t m;
    m = WINDOW_BITS'(w);
    return (m == '0) ? WINDOW_BITS'(1) : m;
  endfunction

endpackage

### hw/rtl/wra_if.sv
interface wra_in_if;
  logic                              valid;
  logic                              ready;
  wra_pkg::op_t                      op;
  logic signed [wra_pkg::DATA_W-1:0] sample;
  logic [wra_pkg::WIN_IN_W-1:0]      window;

  modport source (output valid, op, sample, window, input ready);
  modport sink   (input valid, op, sample, window, output ready);
endinterface

interface wra_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wra_pkg::DATA_W-1:0] average;
  logic [wra_pkg::SEEN_W-1:0]        samples_seen;

  modport source (output valid, average, samples_seen, input ready);
  modport sink   (input valid, average, samples_seen, output ready);
endinterface

### hw/rtl/wra_serial_div.sv
module wra_serial_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [wra_pkg::NUM_W-1:0]        dividend,
  input  logic [wra_pkg::WINDOW_BITS-1:0]  divisor,
  output logic                             done,
  output logic [wra_pkg::NUM_W-1:0]        quotient
);
  import wra_pkg::*;

  logic [WINDOW_BITS-1:0] rem_r, rem_nxt;
  logic [WINDOW_BITS-1:0] den_r, den_nxt;
  logic [NUM_W-1:0]       nq_r, nq_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [WINDOW_BITS:0]   trial;
  logic [WINDOW_BITS:0]   diff;
  logic                   ge;

  // Restoring division: the dividend shifts out of the top of nq_r one bit
  // per cycle while quotient bits shift in at the bottom.
  assign trial = {rem_r, nq_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nq_nxt   = nq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      nq_nxt   = dividend;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[WINDOW_BITS-1:0] : trial[WINDOW_BITS-1:0];
      nq_nxt  = {nq_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nq_r  <= nq_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = nq_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

### hw/rtl/windowed_running_average.sv
// Channel  Dir  Fields                         Beat when
// in_ch    in   op, sample, window             valid && ready
// out_ch   out  average, samples_seen           valid && ready
//
// Update and rescale run WINDOW_BITS multiply steps, then NUM_W restoring
// divide steps, between one accepted beat and the next. Init and clear skip
// both and go straight to the done state.
// Reset (synchronous, active low) clears the average and count and loads
// the default window. A new beat is taken while a result waits in the
// output register; only a result that finds that register full stalls.
module windowed_running_average (
  input  logic      clk,
  input  logic      rst_n,
  wra_in_if.sink    in_ch,
  wra_out_if.source out_ch
);
  import wra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] avg_r, avg_nxt;
  win_t                     cnt_r, cnt_nxt;
  win_t                     win_r, win_nxt;
  win_t                     wgt_r, wgt_nxt;
  win_t                     den_r, den_nxt;
  logic signed [NUM_W-1:0]  acc_r, acc_nxt;
  logic signed [NUM_W-1:0]  mcand_r, mcand_nxt;
  logic [MUL_CNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic                     div_start_r, div_start_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_avg_r, out_avg_nxt;
  logic [SEEN_W-1:0]        out_seen_r, out_seen_nxt;

  win_t                     new_win;
  num_t                     acc_mag;
  logic                     div_done;
  num_t                     div_quo;
  logic                     pos_ovf;
  logic                     neg_ovf;
  logic signed [DATA_W-1:0] div_avg;
  num_t                     quo_neg;

  assign new_win = legal_window(in_ch.window);
  assign acc_mag = acc_r[NUM_W-1] ? (~acc_r + NUM_W'(1)) : acc_r;
  assign quo_neg = ~div_quo + NUM_W'(1);

  wra_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (acc_mag),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Saturate the signed quotient to the Q15.16 range.
  assign pos_ovf = |div_quo[NUM_W-1:DATA_W-1];
  assign neg_ovf = (|div_quo[NUM_W-1:DATA_W]) ||
                   (div_quo[DATA_W-1] && (|div_quo[DATA_W-2:0]));

  always_comb begin
    if (acc_r[NUM_W-1]) begin
      div_avg = neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : quo_neg[DATA_W-1:0];
    end else begin
      div_avg = pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : div_quo[DATA_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    cnt_nxt       = cnt_r;
    win_nxt       = win_r;
    wgt_nxt       = wgt_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mcnt_nxt      = mcnt_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_seen_nxt  = out_seen_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mcnt_nxt = '0;
          unique case (in_ch.op)
            OP_UPDATE: begin
              acc_nxt   = NUM_W'(in_ch.sample);
              mcand_nxt = NUM_W'(avg_r);
              if (cnt_r < win_r) begin
                wgt_nxt = cnt_r;
                den_nxt = cnt_r + WINDOW_BITS'(1);
                cnt_nxt = cnt_r + WINDOW_BITS'(1);
              end else begin
                wgt_nxt = win_r - WINDOW_BITS'(1);
                den_nxt = win_r;
              end
              state_nxt = S_MUL;
            end
            OP_INIT: begin
              win_nxt   = new_win;
              avg_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            OP_CLEAR: begin
              avg_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            OP_RESCALE: begin
              acc_nxt   = '0;
              mcand_nxt = NUM_W'(avg_r);
              wgt_nxt   = win_r;
              den_nxt   = new_win;
              win_nxt   = new_win;
              state_nxt = S_MUL;
            end
          endcase
        end
      end
      S_MUL: begin
        // One weight bit per cycle, least significant first.
        if (wgt_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt = mcand_r <<< 1;
        wgt_nxt   = wgt_r >> 1;
        mcnt_nxt  = mcnt_r + MUL_CNT_W'(1);
        if (mcnt_r == MUL_CNT_W'(WINDOW_BITS - 1)) begin
          div_start_nxt = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_nxt   = div_avg;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_seen_nxt  = SEEN_W'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avg_r       <= '0;
      cnt_r       <= '0;
      win_r       <= DEFAULT_WINDOW;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      cnt_r       <= cnt_nxt;
      win_r       <= win_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wgt_r      <= wgt_nxt;
    den_r      <= den_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mcnt_r     <= mcnt_nxt;
    out_avg_r  <= out_avg_nxt;
    out_seen_r <= out_seen_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.average      = out_avg_r;
  assign out_ch.samples_seen = out_seen_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_INIT) |=>
      (cnt_r == '0 && avg_r == '0 && win_r != '0))
    else $error("init did not clear the average");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished item");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (den_r != '0))
    else $error("divide started with a zero divisor");

endmodule

### verif/windowed_running_average_tb.sv
`timescale 1ns / 100ps

module windowed_running_average_tb;
  import wra_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int OPENING_ROWS = 25;
  localparam int TAIL_CYCLES  = 64;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] sample;
    logic [WIN_IN_W-1:0]      window;
  } avg_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic [SEEN_W-1:0]        seen;
  } avg_result_t;

  typedef struct packed {
    op_t                 op;
    logic [DATA_W-1:0]   sample;
    logic [WIN_IN_W-1:0] window;
    bit                  typed;
    logic [DATA_W-1:0]   exp_avg;
    logic [SEEN_W-1:0]   exp_seen;
  } script_row_t;

  // Rows marked typed carry a result that follows directly from the state;
  // the others are checked against the running predictor.
  script_row_t opening_script [OPENING_ROWS] = '{
    '{OP_UPDATE,  32'h7FFF_FFFF, 10'd0,    1'b1, 32'h7FFF_FFFF, 10'd1},
    '{OP_UPDATE,  32'h8000_0000, 10'd0,    1'b1, 32'h0000_0000, 10'd2},
    '{OP_UPDATE,  32'hFFFF_FFFD, 10'd0,    1'b1, 32'hFFFF_FFFF, 10'd3},
    '{OP_CLEAR,   32'h0000_0000, 10'd0,    1'b1, 32'h0000_0000, 10'd0},
    '{OP_INIT,    32'h0000_0000, 10'd0,    1'b1, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'h1234_5678, 10'd0,    1'b1, 32'h1234_5678, 10'd1},
    '{OP_UPDATE,  32'hFFFF_FFFB, 10'd0,    1'b1, 32'hFFFF_FFFB, 10'd1},
    '{OP_RESCALE, 32'h0000_0000, 10'd1023, 1'b1, 32'h0000_0000, 10'd1},
    '{OP_UPDATE,  32'h7FFF_FFFF, 10'd0,    1'b1, 32'h3FFF_FFFF, 10'd2},
    '{OP_UPDATE,  32'h7FFF_FFFF, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_RESCALE, 32'h0000_0000, 10'd1,    1'b1, 32'h7FFF_FFFF, 10'd3},
    '{OP_UPDATE,  32'h8000_0000, 10'd0,    1'b1, 32'h8000_0000, 10'd3},
    '{OP_RESCALE, 32'h0000_0000, 10'd0,    1'b1, 32'h8000_0000, 10'd3},
    '{OP_RESCALE, 32'h0000_0000, 10'd2,    1'b1, 32'hC000_0000, 10'd3},
    '{OP_UPDATE,  32'h8000_0000, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_RESCALE, 32'h0000_0000, 10'd1,    1'b1, 32'h8000_0000, 10'd3},
    '{OP_INIT,    32'hFFFF_FFFF, 10'd1023, 1'b1, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'hFFFF_FFFF, 10'd1023, 1'b1, 32'hFFFF_FFFF, 10'd1},
    '{OP_UPDATE,  32'h0000_0001, 10'd0,    1'b1, 32'h0000_0000, 10'd2},
    '{OP_INIT,    32'h0000_0000, 10'd3,    1'b1, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'h0001_0000, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'h0002_0000, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'h0003_0000, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_UPDATE,  32'h0004_0000, 10'd0,    1'b0, 32'h0000_0000, 10'd0},
    '{OP_INIT,    32'h0000_0000, 10'd10,   1'b1, 32'h0000_0000, 10'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  wra_in_if  in_ch ();
  wra_out_if out_ch ();

  windowed_running_average DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Running copy of the block's state.
  logic signed [DATA_W-1:0] run_avg    = '0;
  win_t                     run_count  = '0;
  win_t                     run_window = DEFAULT_WINDOW;

  avg_result_t pending_results [$];
  avg_result_t oldest;

  int fail_count        = 0;
  int results_checked   = 0;
  int geometric_updates = 0;
  int saturations       = 0;
  int cycles            = 0;
  int op_beats [4]      = '{0, 0, 0, 0};

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > Q_HI) begin
      saturations++;
      return DATA_W'(Q_HI);
    end
    if (v < Q_LO) begin
      saturations++;
      return DATA_W'(Q_LO);
    end
    return DATA_W'(v);
  endfunction

  function automatic win_t fold_window(input logic [WIN_IN_W-1:0] w);
    win_t masked;
    masked = w[WINDOW_BITS-1:0];
    return (masked == '0) ? win_t'(1) : masked;
  endfunction

  function automatic avg_result_t advance_average(input avg_item_t item);
    longint      weight;
    longint      divisor;
    longint      acc;
    avg_result_t res;
    case (item.op)
      OP_UPDATE: begin
        if (run_count < run_window) begin
          weight    = longint'(run_count);
          run_count = run_count + 1'b1;
          divisor   = weight + 1;
        end else begin
          weight  = longint'(run_window) - 1;
          divisor = longint'(run_window);
          geometric_updates++;
        end
        acc     = weight * longint'(run_avg) + longint'($signed(item.sample));
        run_avg = clamp32(acc / divisor);
      end
      OP_INIT: begin
        run_window = fold_window(item.window);
        run_avg    = '0;
        run_count  = '0;
      end
      OP_CLEAR: begin
        run_avg   = '0;
        run_count = '0;
      end
      default: begin
        // The count is kept, so it may now sit above the new window.
        acc        = longint'(run_avg) * longint'(run_window);
        run_window = fold_window(item.window);
        run_avg    = clamp32(acc / longint'(run_window));
      end
    endcase
    res.average = run_avg;
    res.seen    = run_count;
    return res;
  endfunction

  function automatic avg_item_t random_item();
    avg_item_t item;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) item.op = OP_UPDATE;
    else if (pick < 87) item.op = OP_RESCALE;
    else if (pick < 95) item.op = OP_INIT;
    else item.op = OP_CLEAR;

    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      item.sample = $urandom;
    end else if (pick < 70) begin
      item.sample = DATA_W'($urandom_range(0, 32'h0020_0000)) - DATA_W'(32'h0010_0000);
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: item.sample = 32'h7FFF_FFFF;
        1: item.sample = 32'h8000_0000;
        2: item.sample = '0;
        default: item.sample = '1;
      endcase
    end else begin
      item.sample = (DATA_W'($urandom_range(0, 200)) - DATA_W'(100)) << 16;
    end

    // Mostly small windows so that updates soon reach the geometric branch.
    pick = $urandom_range(0, 99);
    if (pick < 55) item.window = WIN_IN_W'($urandom_range(1, 12));
    else if (pick < 70) item.window = WIN_IN_W'($urandom_range(13, 100));
    else if (pick < 82) item.window = WIN_IN_W'($urandom_range(101, 1022));
    else if (pick < 90) item.window = '1;
    else if (pick < 95) item.window = '0;
    else item.window = WIN_IN_W'($urandom);
    return item;
  endfunction

  // Drives one beat at the falling edge and holds it until the block takes it.
  task automatic push_beat(input avg_item_t item, input bit typed, input avg_result_t typed_res);
    avg_result_t predicted;
    in_ch.valid  <= 1'b1;
    in_ch.op     <= item.op;
    in_ch.sample <= item.sample;
    in_ch.window <= item.window;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_average(item);
    pending_results.push_back(typed ? typed_res : predicted);
    op_beats[item.op]++;
    @(negedge clk);
  endtask

  task automatic hold_off(input int gap, input bit until_empty);
    in_ch.valid <= 1'b0;
    repeat (gap) @(negedge clk);
    while (until_empty && pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: picks a new stall pattern whenever the current one runs out.
  int rx_mode   = 0;
  int rx_left   = 0;
  int rx_period = 1;
  int rx_phase  = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_left   = $urandom_range(50, 400);
      rx_period = $urandom_range(4, 160);
      rx_phase  = 0;
    end else begin
      rx_left--;
    end
    rx_phase = (rx_phase + 1) % rx_period;
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 2) != 0);
      2: out_ch.ready <= (rx_phase >= rx_period / 2);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: average %0d, samples_seen %0d",
               out_ch.average, out_ch.samples_seen);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.average !== oldest.average) begin
          $error("average: expected %0d, got %0d", oldest.average, out_ch.average);
          fail_count++;
        end
        if (out_ch.samples_seen !== oldest.seen) begin
          $error("samples_seen: expected %0d, got %0d", oldest.seen, out_ch.samples_seen);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycles, pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    avg_item_t   item;
    avg_result_t typed_res;
    int          sent;
    int          burst;
    bit          drained;

    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_UPDATE;
    in_ch.sample <= '0;
    in_ch.window <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_script[i]) begin
      item.op           = opening_script[i].op;
      item.sample       = opening_script[i].sample;
      item.window       = opening_script[i].window;
      typed_res.average = opening_script[i].exp_avg;
      typed_res.seen    = opening_script[i].exp_seen;
      push_beat(item, opening_script[i].typed, typed_res);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 70), 1'b0);
    end

    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        push_beat(random_item(), 1'b0, '0);
        sent++;
        burst--;
      end
      // Halfway through, let the pipeline run dry at least once.
      if ((!drained && sent >= RANDOM_ITEMS / 2) || $urandom_range(0, 15) == 0) begin
        hold_off(1, 1'b1);
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 70), 1'b0);
      end
    end

    hold_off(1, 1'b1);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d beats: %0d update, %0d init, %0d clear, %0d rescale; %0d results checked.",
             OPENING_ROWS + RANDOM_ITEMS, op_beats[OP_UPDATE], op_beats[OP_INIT],
             op_beats[OP_CLEAR], op_beats[OP_RESCALE], results_checked);
    $display("%0d updates used the geometric branch, %0d results saturated, %0d cycles.",
             geometric_updates, saturations, cycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
